### rtl/osp_pkg.sv
// Shared types and constants of the object slot pool.
package osp_pkg;

  localparam int unsigned PoolSlots = 32;
  localparam int unsigned SlotIdxW  = $clog2(PoolSlots);
  localparam int unsigned SlotW     = 6;

  typedef logic [SlotW-1:0]    slot_t;
  typedef logic [SlotIdxW-1:0] slot_idx_t;

  localparam slot_t     EndMark  = slot_t'(PoolSlots);
  localparam slot_idx_t LastStep = slot_idx_t'(PoolSlots - 1);

  typedef enum logic [1:0] {
    OP_SPAWN   = 2'd0,
    OP_DESPAWN = 2'd1,
    OP_FIND    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] kind;
    slot_t      slot;
  } in_item_t;

  typedef struct packed {
    logic       ok;
    slot_t      slot_out;
    logic [7:0] kind_out;
  } out_item_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] kind;
  } slot_data_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SP_WR,
    ST_DS_LS,
    ST_WALK,
    ST_DS_FIN,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    RD_FREE,
    RD_SLOT,
    RD_ACTIVE,
    RD_NEXT
  } rd_src_e;

  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    rd_src_e rd_src;
    logic    sp_commit;
    logic    ls_load;
    logic    act_from_link;
    logic    link_patch;
    logic    ds_commit;
    logic    find_hit;
    logic    out_load;
  } osp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic free_is_slot;
    logic slot_is_slot;
    logic active_is_slot;
    logic active_eq_slot;
    logic hit;
    logic walk_last;
    logic out_free;
  } osp_status_t;

endpackage

### rtl/osp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module osp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/osp_ctrl.sv
// Control state machine of the object slot pool.
module osp_ctrl import osp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  osp_status_t status_i,
  output osp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (status_i.op)
          OP_SPAWN:   state_d = status_i.free_is_slot ? ST_SP_WR : ST_RESP;
          OP_DESPAWN: state_d = status_i.slot_is_slot ? ST_DS_LS : ST_RESP;
          OP_FIND:    state_d = status_i.active_is_slot ? ST_WALK : ST_RESP;
          default:    state_d = ST_RESP;
        endcase
      end
      ST_SP_WR: state_d = ST_RESP;
      ST_DS_LS: begin
        priority if (status_i.active_eq_slot) state_d = ST_DS_FIN;
        else if (status_i.active_is_slot)     state_d = ST_WALK;
        else                                  state_d = ST_DS_FIN;
      end
      ST_WALK: begin
        if (status_i.hit || status_i.walk_last) begin
          state_d = (status_i.op == OP_FIND) ? ST_RESP : ST_DS_FIN;
        end
      end
      ST_DS_FIN: state_d = ST_RESP;
      ST_RESP: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o      = '0;
    cmd_o.rd_src = RD_FREE;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
      end
      ST_DECODE: begin
        unique case (status_i.op)
          OP_SPAWN: begin
            cmd_o.rd_en  = status_i.free_is_slot;
            cmd_o.rd_src = RD_FREE;
          end
          OP_DESPAWN: begin
            cmd_o.rd_en  = status_i.slot_is_slot;
            cmd_o.rd_src = RD_SLOT;
          end
          OP_FIND: begin
            cmd_o.rd_en  = status_i.active_is_slot;
            cmd_o.rd_src = RD_ACTIVE;
          end
          default: cmd_o.rd_en = 1'b0;
        endcase
      end
      ST_SP_WR: cmd_o.sp_commit = 1'b1;
      ST_DS_LS: begin
        cmd_o.ls_load = 1'b1;
        priority if (status_i.active_eq_slot) begin
          cmd_o.act_from_link = 1'b1;
        end else if (status_i.active_is_slot) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_ACTIVE;
        end
      end
      ST_WALK: begin
        priority if (status_i.hit) begin
          cmd_o.find_hit   = (status_i.op == OP_FIND);
          cmd_o.link_patch = (status_i.op != OP_FIND);
        end else if (!status_i.walk_last) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_NEXT;
        end
      end
      ST_DS_FIN: cmd_o.ds_commit = 1'b1;
      ST_RESP:   cmd_o.out_load  = status_i.out_free;
      default:   in_stall_o      = 1'b1;
    endcase
  end

endmodule

### rtl/osp_datapath.sv
// Datapath of the object slot pool: slot stores, list heads, walk cursor, result.
module osp_datapath import osp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_data_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output out_item_t   out_beat_o,
  input  osp_cmd_t    cmd_i,
  output osp_status_t status_o
);

  in_item_t   item_q;
  slot_idx_t  cur_q, cur_d;
  slot_idx_t  steps_q, steps_d;
  slot_t      ls_q;
  slot_t      free_head_q, free_head_d;
  slot_t      active_head_q, active_head_d;
  out_item_t  res_q, res_d;
  out_item_t  out_q;
  logic       out_valid_q;
  logic [PoolSlots-1:0] lvalid_q, dvalid_q;
  logic       lv_rd_q, dv_rd_q;

  slot_idx_t  rd_addr, raddr;
  slot_t      link_rdata, link_eff;
  slot_data_t data_rdata, data_eff;
  logic       link_we, data_we;
  slot_idx_t  link_waddr, data_waddr;
  slot_t      link_wdata;
  slot_data_t data_wdata;
  slot_idx_t  slot_idx;

  assign slot_idx = item_q.slot[SlotIdxW-1:0];

  // Entries never written read as their reset value.
  assign link_eff = lv_rd_q ? link_rdata : (slot_t'(cur_q) + slot_t'(1));
  assign data_eff = dv_rd_q ? data_rdata : '0;

  always_comb begin
    unique case (cmd_i.rd_src)
      RD_FREE:   rd_addr = free_head_q[SlotIdxW-1:0];
      RD_SLOT:   rd_addr = slot_idx;
      RD_ACTIVE: rd_addr = active_head_q[SlotIdxW-1:0];
      RD_NEXT:   rd_addr = link_eff[SlotIdxW-1:0];
      default:   rd_addr = cur_q;
    endcase
  end

  assign raddr = cmd_i.rd_en ? rd_addr : cur_q;
  assign cur_d = raddr;

  always_comb begin
    steps_d = steps_q;
    if (cmd_i.rd_en) begin
      steps_d = (cmd_i.rd_src == RD_NEXT) ? steps_q + slot_idx_t'(1) : '0;
    end
  end

  // Write ports.
  always_comb begin
    link_we    = cmd_i.sp_commit | cmd_i.link_patch | cmd_i.ds_commit;
    link_waddr = cmd_i.ds_commit ? slot_idx : cur_q;
    priority if (cmd_i.sp_commit) link_wdata = active_head_q;
    else if (cmd_i.link_patch)    link_wdata = ls_q;
    else                          link_wdata = free_head_q;
    data_we    = cmd_i.sp_commit | cmd_i.ds_commit;
    data_waddr = cmd_i.ds_commit ? slot_idx : cur_q;
    data_wdata = cmd_i.sp_commit ? slot_data_t'{x: item_q.pos_x, y: item_q.pos_y,
                                                kind: item_q.kind} : '0;
  end

  always_comb begin
    free_head_d   = free_head_q;
    active_head_d = active_head_q;
    if (cmd_i.sp_commit) begin
      free_head_d   = link_eff;
      active_head_d = slot_t'(cur_q);
    end
    if (cmd_i.ds_commit)     free_head_d   = item_q.slot;
    if (cmd_i.act_from_link) active_head_d = link_eff;
  end

  always_comb begin
    res_d = res_q;
    priority if (cmd_i.load_item) begin
      res_d = '{ok: 1'b0, slot_out: EndMark, kind_out: 8'd0};
    end else if (cmd_i.sp_commit) begin
      res_d = '{ok: 1'b1, slot_out: slot_t'(cur_q), kind_out: 8'd0};
    end else if (cmd_i.find_hit) begin
      res_d = '{ok: 1'b1, slot_out: slot_t'(cur_q), kind_out: data_eff.kind};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q   <= '0;
      active_head_q <= EndMark;
      lvalid_q      <= '0;
      dvalid_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      free_head_q   <= free_head_d;
      active_head_q <= active_head_d;
      if (link_we) lvalid_q[link_waddr] <= 1'b1;
      if (data_we) dvalid_q[data_waddr] <= 1'b1;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
    if (cmd_i.ls_load)   ls_q   <= link_eff;
    if (cmd_i.out_load)  out_q  <= res_q;
    cur_q   <= cur_d;
    steps_q <= steps_d;
    res_q   <= res_d;
    lv_rd_q <= lvalid_q[raddr];
    dv_rd_q <= dvalid_q[raddr];
  end

  osp_ram #(
    .Width(SlotW),
    .Depth(PoolSlots)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(raddr),
    .rdata_o(link_rdata)
  );

  osp_ram #(
    .Width($bits(slot_data_t)),
    .Depth(PoolSlots)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (data_we),
    .waddr_i(data_waddr),
    .wdata_i(data_wdata),
    .raddr_i(raddr),
    .rdata_o(data_rdata)
  );

  always_comb begin
    status_o.op             = op_e'(item_q.opcode);
    status_o.free_is_slot   = free_head_q < EndMark;
    status_o.slot_is_slot   = item_q.slot < EndMark;
    status_o.active_is_slot = active_head_q < EndMark;
    status_o.active_eq_slot = active_head_q == item_q.slot;
    status_o.hit            = (status_o.op == OP_FIND)
                            ? (data_eff.x == item_q.pos_x && data_eff.y == item_q.pos_y)
                            : (link_eff == item_q.slot);
    status_o.walk_last      = !(link_eff < EndMark) || (steps_q == LastStep);
    status_o.out_free       = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

### rtl/object_slot_pool_unit.sv
// Object slot pool: top level joining the control state machine and the datapath.
//
// A pool of 32 object slots kept on two singly linked lists that share one link
// RAM: a free list and an active list. Spawn pops the free head, stores x, y and
// kind and pushes the slot on the active list; despawn walks the active list for
// the slot's predecessor unless it is the head, unlinks it, pushes it on the free
// list and clears it; find walks the active list for the first slot at x, y. One
// item is worked at a time, and every item gives exactly one result beat. A spawn
// on an empty pool, the unused code and a despawn of the null or an out-of-range
// slot go from decode straight to the result. A stalled result holds the block in
// its result state until the output register frees. The walk visits one node a
// cycle: the registered read of the link RAM feeds the next read address directly,
// so the link RAM read port sets the step rate, and every walk is bounded to 32
// nodes. Reset needs no clearing pass: per-entry valid bits make unwritten slots
// read as their reset contents. A finished result waits in an output register
// while the next beat is accepted.
module object_slot_pool_unit import osp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_beat_o
);

  osp_cmd_t    cmd;
  osp_status_t status;

  // Sequence each operation: decode, reads, walk, commit, result.
  osp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Hold slot stores, list heads, walk cursor and the output register.
  osp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_beat_o (out_beat_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

### rtl/osp_checker.sv
// Port-level checks of the object slot pool and their bind to the top level.
module osp_checker import osp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_beat_o
);

  // Take no second beat right after one is accepted.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on the cycle after an accepted beat");

  // A success names a real slot.
  a_ok_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.ok |-> out_beat_o.slot_out < EndMark)
    else $error("successful result without a slot");

  // A failure carries the end marker and no kind.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.ok |->
      out_beat_o.slot_out == EndMark && out_beat_o.kind_out == 8'd0)
    else $error("failed result with slot or kind set");

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled result beat changed");

endmodule

bind object_slot_pool_unit osp_checker u_osp_checker (.*);

### test/slot_pool_checker.sv
// Checker for the object slot pool: tracks both lists and compares every result beat.
module slot_pool_checker import osp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_beat_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] pos_x_mem [PoolSlots];
  logic [7:0] pos_y_mem [PoolSlots];
  logic [7:0] kind_mem  [PoolSlots];
  slot_t      link_mem  [PoolSlots];
  slot_t      free_head;
  slot_t      active_head;
  out_item_t  due_results [$];

  function automatic void clear_pool();
    for (int i = 0; i < PoolSlots; i++) begin
      pos_x_mem[i] = '0;
      pos_y_mem[i] = '0;
      kind_mem[i]  = '0;
      link_mem[i]  = slot_t'(i + 1);
    end
    free_head   = '0;
    active_head = EndMark;
  endfunction

  // Unlink from the active list if found, then push on the free list regardless.
  function automatic void release_slot(input slot_t s);
    slot_t       cur;
    int unsigned steps;
    bit          found;
    if (active_head == s) begin
      active_head = link_mem[s[SlotIdxW-1:0]];
    end else begin
      cur   = active_head;
      steps = 0;
      found = 1'b0;
      while (cur < EndMark && steps < PoolSlots && !found) begin
        if (link_mem[cur[SlotIdxW-1:0]] == s) begin
          found = 1'b1;
        end else begin
          cur = link_mem[cur[SlotIdxW-1:0]];
          steps++;
        end
      end
      if (found) link_mem[cur[SlotIdxW-1:0]] = link_mem[s[SlotIdxW-1:0]];
    end
    link_mem[s[SlotIdxW-1:0]]  = free_head;
    free_head                  = s;
    pos_x_mem[s[SlotIdxW-1:0]] = '0;
    pos_y_mem[s[SlotIdxW-1:0]] = '0;
    kind_mem[s[SlotIdxW-1:0]]  = '0;
  endfunction

  function automatic out_item_t apply_pool_op(input in_item_t item);
    out_item_t   res;
    slot_t       n;
    slot_t       cur;
    int unsigned steps;
    bit          hit;
    res.ok       = 1'b0;
    res.slot_out = EndMark;
    res.kind_out = '0;
    case (item.opcode)
      OP_SPAWN: begin
        n = free_head;
        if (n < EndMark) begin
          free_head                  = link_mem[n[SlotIdxW-1:0]];
          pos_x_mem[n[SlotIdxW-1:0]] = item.pos_x;
          pos_y_mem[n[SlotIdxW-1:0]] = item.pos_y;
          kind_mem[n[SlotIdxW-1:0]]  = item.kind;
          link_mem[n[SlotIdxW-1:0]]  = active_head;
          active_head                = n;
          res.ok                     = 1'b1;
          res.slot_out               = n;
        end
      end
      OP_DESPAWN: begin
        if (item.slot < EndMark) release_slot(item.slot);
      end
      OP_FIND: begin
        cur   = active_head;
        steps = 0;
        hit   = 1'b0;
        while (cur < EndMark && steps < PoolSlots && !hit) begin
          if (pos_x_mem[cur[SlotIdxW-1:0]] == item.pos_x &&
              pos_y_mem[cur[SlotIdxW-1:0]] == item.pos_y) begin
            hit          = 1'b1;
            res.ok       = 1'b1;
            res.slot_out = cur;
            res.kind_out = kind_mem[cur[SlotIdxW-1:0]];
          end else begin
            cur = link_mem[cur[SlotIdxW-1:0]];
            steps++;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Print only the first hundred mismatches, but count them all.
  task automatic report_mismatch(input string what, input int unsigned got, want);
    fail_count_o++;
    if (fail_count_o <= 100)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      clear_pool();
      due_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result beat with nothing due, slot_out",
                          32'(out_beat_i.slot_out), 0);
        end else begin
          want = due_results.pop_front();
          if (out_beat_i.ok !== want.ok)
            report_mismatch("ok", 32'(out_beat_i.ok), 32'(want.ok));
          if (out_beat_i.slot_out !== want.slot_out)
            report_mismatch("slot_out", 32'(out_beat_i.slot_out), 32'(want.slot_out));
          if (out_beat_i.kind_out !== want.kind_out)
            report_mismatch("kind_out", 32'(out_beat_i.kind_out), 32'(want.kind_out));
        end
      end
      if (in_valid_i && !in_stall_i) due_results.push_back(apply_pool_op(in_data_i));
    end
    pending_o = due_results.size();
  end

endmodule

### test/object_slot_pool_unit_tb.sv
// Testbench top for the object slot pool: stimulus, backpressure and verdict.
module object_slot_pool_unit_tb import osp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // The hang limit is set far above what about 1200 beats with the longest gaps
  // and output stalls can take.
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = 40;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_beat;
  int unsigned fail_count;
  int unsigned pending;

  // Calm stretches: no input gaps and no output stalls.
  bit          calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;

  // Slots known to be on the active list, learned from spawn results.
  slot_t       live_slots [$];
  logic [1:0]  sent_ops [$];

  object_slot_pool_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  slot_pool_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_beat_i  (out_beat),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned stall_burst();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Output backpressure: update at the falling edge only.
  always @(negedge clk) begin : stall_gen
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if ($urandom_range(0, 99) < 55) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      hold_left = stall_burst() - 1;
    end
  end

  // Learn allocated slots from spawn results so despawns can target live ones.
  always @(posedge clk) begin : slot_tracker
    logic [1:0] op;
    if (rst_n && out_valid && !out_stall && sent_ops.size() != 0) begin
      op = sent_ops.pop_front();
      if (op == OP_SPAWN && out_beat.ok) live_slots.push_back(out_beat.slot_out);
    end
    if (rst_n && in_valid && !in_stall) sent_ops.push_back(in_data.opcode);
  end

  function automatic in_item_t make_item(input op_e op, input logic [7:0] x, y, k,
                                         input slot_t s);
    in_item_t it;
    it.opcode = op;
    it.pos_x  = x;
    it.pos_y  = y;
    it.kind   = k;
    it.slot   = s;
    return it;
  endfunction

  function automatic in_item_t noisy_item();
    in_item_t it;
    it.opcode = 2'($urandom_range(0, 3));
    it.pos_x  = 8'($urandom_range(0, 255));
    it.pos_y  = 8'($urandom_range(0, 255));
    it.kind   = 8'($urandom_range(0, 255));
    it.slot   = 6'($urandom_range(0, 63));
    return it;
  endfunction

  // Well-formed traffic with a little noise. Positions cluster in a small
  // square so finds hit often and duplicate positions occur.
  function automatic in_item_t next_item(input int unsigned spawn_pct);
    in_item_t    it;
    int unsigned r;
    int unsigned idx;
    it = noisy_item();
    r  = $urandom_range(0, 99);
    if (r < 6) begin
      case ($urandom_range(0, 2))
        0: it.opcode = OP_NONE;
        1: begin
          it.opcode = OP_DESPAWN;
          it.slot   = 6'($urandom_range(32, 63));
        end
        default: it.opcode = OP_FIND;
      endcase
      return it;
    end
    if ($urandom_range(0, 99) < 75) begin
      it.pos_x = 8'($urandom_range(0, 5));
      it.pos_y = 8'($urandom_range(0, 5));
    end
    if ($urandom_range(0, 99) < spawn_pct) begin
      it.opcode = OP_SPAWN;
    end else if (live_slots.size() != 0 && $urandom_range(0, 1) == 1) begin
      idx       = $urandom_range(0, live_slots.size() - 1);
      it.opcode = OP_DESPAWN;
      it.slot   = live_slots[idx];
      live_slots.delete(idx);
    end else begin
      it.opcode = OP_FIND;
    end
    return it;
  endfunction

  // Leave a random gap, then stand at a falling edge ready to drive.
  task automatic pace();
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
  endtask

  // Drive one beat and hold it until taken.
  task automatic push_beat(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send(input in_item_t it);
    pace();
    push_beat(it);
  endtask

  int unsigned spawn_mix [10] = '{90, 55, 25, 70, 95, 35, 60, 15, 80, 50};

  initial begin : stimulus
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, extremes, duplicate positions, null and
    // out-of-range despawns, unused opcode, unlink at head, middle and tail.
    send(make_item(OP_FIND,    8'd0,   8'd0,   8'd0,   6'd0));
    send(make_item(OP_SPAWN,   8'd0,   8'd0,   8'd0,   6'd0));
    send(make_item(OP_SPAWN,   8'hFF,  8'hFF,  8'hFF,  6'd63));
    send(make_item(OP_SPAWN,   8'd12,  8'd34,  8'h5A,  6'd0));
    send(make_item(OP_SPAWN,   8'd12,  8'd34,  8'hA5,  6'd0));
    send(make_item(OP_FIND,    8'hFF,  8'hFF,  8'd0,   6'd0));
    send(make_item(OP_FIND,    8'd0,   8'd0,   8'd0,   6'd0));
    send(make_item(OP_FIND,    8'd12,  8'd34,  8'd0,   6'd0));
    send(make_item(OP_FIND,    8'd1,   8'd2,   8'd0,   6'd0));
    send(make_item(OP_DESPAWN, 8'd0,   8'd0,   8'd0,   EndMark));
    send(make_item(OP_DESPAWN, 8'd0,   8'd0,   8'd0,   6'd40));
    send(make_item(OP_DESPAWN, 8'hFF,  8'hFF,  8'hFF,  6'd63));
    send(make_item(OP_NONE,    8'hFF,  8'hFF,  8'hFF,  6'd63));
    send(make_item(OP_NONE,    8'd0,   8'd0,   8'd0,   6'd0));
    send(make_item(OP_DESPAWN, 8'd0,   8'd0,   8'd0,   6'd3));
    send(make_item(OP_FIND,    8'd12,  8'd34,  8'd0,   6'd0));
    send(make_item(OP_DESPAWN, 8'd0,   8'd0,   8'd0,   6'd1));
    send(make_item(OP_FIND,    8'hFF,  8'hFF,  8'd0,   6'd0));
    send(make_item(OP_DESPAWN, 8'd0,   8'd0,   8'd0,   6'd0));
    send(make_item(OP_SPAWN,   8'd7,   8'd7,   8'h11,  6'd0));
    send(make_item(OP_FIND,    8'd7,   8'd7,   8'd0,   6'd0));
    // Slot 2 was spawned above and is still live.
    live_slots.push_back(6'd2);

    // Random phases; the spawn-heavy first one drains the pool to empty.
    for (int ph = 0; ph < 10; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 110; k++) begin
        pace();
        push_beat(next_item(spawn_mix[ph]));
      end
    end
    calm = 1'b0;

    // Broken sequences last: a double despawn makes a self loop on the free
    // list, two spawns then close the active list on itself, and the walks
    // must give up at the bound.
    send(make_item(OP_DESPAWN, 8'd0,   8'd0,   8'd0,   6'd5));
    send(make_item(OP_DESPAWN, 8'd0,   8'd0,   8'd0,   6'd5));
    send(make_item(OP_SPAWN,   8'd3,   8'd4,   8'h21,  6'd0));
    send(make_item(OP_SPAWN,   8'd3,   8'd4,   8'h42,  6'd0));
    send(make_item(OP_FIND,    8'd3,   8'd4,   8'd0,   6'd0));
    send(make_item(OP_FIND,    8'd250, 8'd251, 8'd0,   6'd0));
    send(make_item(OP_DESPAWN, 8'd0,   8'd0,   8'd0,   6'd9));
    for (int k = 0; k < 40; k++) send(noisy_item());

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every due result, then watch for strays.
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/osp_pkg.sv
rtl/osp_ram.sv
rtl/osp_ctrl.sv
rtl/osp_datapath.sv
rtl/object_slot_pool_unit.sv
rtl/osp_checker.sv
test/slot_pool_checker.sv
test/object_slot_pool_unit_tb.sv
